// ===== rtl/core/shifted_cone_projection_3d_defines.svh =====
// ----------------------------------------------------------------------------
// Shifted cone projection assertion macros
// Shared property forms for the checker of the cone projection block.
// ----------------------------------------------------------------------------
`ifndef SHIFTED_CONE_PROJECTION_3D_DEFINES_SVH
`define SHIFTED_CONE_PROJECTION_3D_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shifted cone projection package
// Case codes, default width and the stage control type shared by the cells.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] CASE_INSIDE  = 2'd0;
	localparam logic [1:0] CASE_APEX    = 2'd1;
	localparam logic [1:0] CASE_SURFACE = 2'd2;

	typedef struct packed {
		logic en;
		logic vld;
	} stage_ctl_t;

endpackage

// ===== rtl/core/scp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cell from two radicand bits and passes the
// partial root, the remainder and the item payload to the next cell.
// ----------------------------------------------------------------------------
module scp_sqrt_cell #(
	parameter int W  = 32,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::stage_ctl_t ctl,
	input  logic [W+1:0]      rem_in,
	input  logic [W-1:0]      root_in,
	input  logic [2*W-1:0]    rad_in,
	input  logic [PW-1:0]     pay_in,
	output logic              vld_out,
	output logic [W+1:0]      rem_out,
	output logic [W-1:0]      root_out,
	output logic [2*W-1:0]    rad_out,
	output logic [PW-1:0]     pay_out
);
	import scp_pkg::*;

	logic [W+3:0] cur;
	logic [W+3:0] trial;
	logic [W+3:0] diff;
	logic         ge;
	logic         vld_q;
	logic [W+1:0] rem_q;
	logic [W-1:0] root_q;
	logic [2*W-1:0] rad_q;
	logic [PW-1:0] pay_q;

	assign cur   = {rem_in, rad_in[2*W-1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign diff  = cur - trial;
	assign ge    = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rem_q  <= ge ? diff[W+1:0] : cur[W+1:0];
			root_q <= {root_in[W-2:0], ge};
			rad_q  <= {rad_in[2*W-3:0], 2'b00};
			pay_q  <= pay_in;
		end
	end

	assign vld_out  = vld_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign rad_out  = rad_q;
	assign pay_out  = pay_q;

endmodule

// ===== rtl/core/scp_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit for each of the two tail lanes against the
// shared divisor and passes both partial remainders on.
// ----------------------------------------------------------------------------
module scp_div_cell #(
	parameter int W  = 32,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::stage_ctl_t ctl,
	input  logic [W-1:0]      rem_a_in,
	input  logic [W-1:0]      low_a_in,
	input  logic [W-1:0]      rem_b_in,
	input  logic [W-1:0]      low_b_in,
	input  logic [W-1:0]      den_in,
	input  logic [PW-1:0]     pay_in,
	output logic              vld_out,
	output logic [W-1:0]      rem_a_out,
	output logic [W-1:0]      low_a_out,
	output logic [W-1:0]      rem_b_out,
	output logic [W-1:0]      low_b_out,
	output logic [W-1:0]      den_out,
	output logic [PW-1:0]     pay_out
);
	import scp_pkg::*;

	logic [W:0]   xa;
	logic [W:0]   xb;
	logic [W:0]   da;
	logic [W:0]   db;
	logic         gea;
	logic         geb;
	logic         vld_q;
	logic [W-1:0] rem_a_q;
	logic [W-1:0] low_a_q;
	logic [W-1:0] rem_b_q;
	logic [W-1:0] low_b_q;
	logic [W-1:0] den_q;
	logic [PW-1:0] pay_q;

	assign xa  = {rem_a_in, low_a_in[W-1]};
	assign xb  = {rem_b_in, low_b_in[W-1]};
	assign gea = (xa >= {1'b0, den_in});
	assign geb = (xb >= {1'b0, den_in});
	assign da  = xa - {1'b0, den_in};
	assign db  = xb - {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rem_a_q <= gea ? da[W-1:0] : xa[W-1:0];
			rem_b_q <= geb ? db[W-1:0] : xb[W-1:0];
			low_a_q <= {low_a_in[W-2:0], gea};
			low_b_q <= {low_b_in[W-2:0], geb};
			den_q   <= den_in;
			pay_q   <= pay_in;
		end
	end

	assign vld_out   = vld_q;
	assign rem_a_out = rem_a_q;
	assign low_a_out = low_a_q;
	assign rem_b_out = rem_b_q;
	assign low_b_out = low_b_q;
	assign den_out   = den_q;
	assign pay_out   = pay_q;

endmodule

// ===== rtl/core/shifted_cone_projection_3d.sv =====
// ----------------------------------------------------------------------------
// Shifted second-order cone projection, three dimensions
// Projects one vector per transaction onto the shifted cone and reports
// which of the three cases applied.
//
// Channel   Role    Contents
// s_axis    input   tdata: head, tail_a, tail_b, shift; tuser: cone_negative
// m_axis    output  tdata: proj_head, proj_tail_a, proj_tail_b; tuser: case_taken
//
// One transaction is accepted per cycle while s_tready is high.
// The pipeline holds DATA_WIDTH root cells and DATA_WIDTH
// divider cells, plus six registered stages around them.
// Reset clears only the valid flags; no clearing pass is needed.
// A stalled output fills a one-entry skid register, after which the whole
// chain holds and s_tready stays low until the skid entry drains.
// ----------------------------------------------------------------------------
module shifted_cone_projection_3d #(
	parameter int DATA_WIDTH = scp_pkg::DATA_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// head, tail_a, tail_b, shift from bit 0 up, zero padded to bytes
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
	// cone_negative
	input  logic                                    s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// proj_head, proj_tail_a, proj_tail_b from bit 0 up, zero padded to bytes
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
	// case_taken
	output logic [1:0]                              m_tuser
);
	import scp_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int OUT_TW = ((3*W+7)/8)*8;
	localparam int PW1    = 6*W+1;
	localparam int PW2    = 5*W+2;

	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	logic en;

	logic [W-1:0] in_head;
	logic [W-1:0] in_ta;
	logic [W-1:0] in_tb;
	logic [W-1:0] in_shift;

	logic         vld_s1;
	logic [W-1:0] head_s1;
	logic [W-1:0] ta_s1;
	logic [W-1:0] tb_s1;
	logic [W-1:0] shift_s1;
	logic         neg_s1;
	logic [W-1:0] ma_s1;
	logic [W-1:0] mb_s1;

	logic           vld_s2;
	logic [2*W-1:0] sqa_s2;
	logic [2*W-1:0] sqb_s2;
	logic [PW1-1:0] pay_s2;

	logic           vld_s3;
	logic [2*W-1:0] sum_s3;
	logic [PW1-1:0] pay_s3;

	stage_ctl_t     sq_ctl [0:W-1];
	logic           sq_vld  [0:W];
	logic [W+1:0]   sq_rem  [0:W];
	logic [W-1:0]   sq_root [0:W];
	logic [2*W-1:0] sq_rad  [0:W];
	logic [PW1-1:0] sq_pay  [0:W];

	logic         r_neg;
	logic [W-1:0] r_head;
	logic [W-1:0] r_ta;
	logic [W-1:0] r_tb;
	logic [W-1:0] r_shift;
	logic [W-1:0] r_ma;
	logic [W-1:0] r_mb;
	logic [W-1:0] norm;
	logic [W:0]   hdiff;
	logic [W:0]   cm;
	logic         c_neg;
	logic         n_le;
	logic [W+1:0] tsum;
	logic [W-1:0] t_val;
	logic [W+1:0] sh_sum;
	logic [W-1:0] rh_sat;
	logic [1:0]   kase;

	logic         vld_s4;
	logic [1:0]   kase_s4;
	logic [W-1:0] rh_s4;
	logic [W-1:0] head_s4;
	logic [W-1:0] ta_s4;
	logic [W-1:0] tb_s4;
	logic [W-1:0] shift_s4;
	logic [W-1:0] ma_s4;
	logic [W-1:0] mb_s4;
	logic [W-1:0] t_s4;
	logic [W-1:0] norm_s4;

	logic           vld_s5;
	logic [2*W-1:0] pa_s5;
	logic [2*W-1:0] pb_s5;
	logic [W-1:0]   norm_s5;
	logic [PW2-1:0] pay_s5;

	stage_ctl_t     dv_ctl   [0:W-1];
	logic           dv_vld   [0:W];
	logic [W-1:0]   dv_rem_a [0:W];
	logic [W-1:0]   dv_low_a [0:W];
	logic [W-1:0]   dv_rem_b [0:W];
	logic [W-1:0]   dv_low_b [0:W];
	logic [W-1:0]   dv_den   [0:W];
	logic [PW2-1:0] dv_pay   [0:W];

	logic [1:0]   f_kase;
	logic [W-1:0] f_head;
	logic [W-1:0] f_ta;
	logic [W-1:0] f_tb;
	logic [W-1:0] f_shift;
	logic [W-1:0] f_rh;
	logic [W-1:0] f_ra;
	logic [W-1:0] f_rb;
	logic [3*W-1:0] f_data;

	logic           out_vld_q;
	logic [3*W-1:0] out_data_q;
	logic [1:0]     out_kase_q;
	logic           skid_vld_q;
	logic [3*W-1:0] skid_data_q;
	logic [1:0]     skid_kase_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	assign in_head  = s_tdata[W-1:0];
	assign in_ta    = s_tdata[2*W-1:W];
	assign in_tb    = s_tdata[3*W-1:2*W];
	assign in_shift = s_tdata[4*W-1:3*W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld[W];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s1  <= in_head;
			ta_s1    <= in_ta;
			tb_s1    <= in_tb;
			shift_s1 <= in_shift;
			neg_s1   <= s_tuser;
			ma_s1    <= in_ta[W-1] ? (~in_ta) + W'(1) : in_ta;
			mb_s1    <= in_tb[W-1] ? (~in_tb) + W'(1) : in_tb;

			sqa_s2 <= ma_s1 * ma_s1;
			sqb_s2 <= mb_s1 * mb_s1;
			pay_s2 <= {neg_s1, head_s1, ta_s1, tb_s1, shift_s1, ma_s1, mb_s1};

			sum_s3 <= sqa_s2 + sqb_s2;
			pay_s3 <= pay_s2;
		end
	end

	assign sq_vld[0]  = vld_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = sum_s3;
	assign sq_pay[0]  = pay_s3;

	for (genvar i = 0; i < W; i++) begin : g_sqrt
		assign sq_ctl[i] = '{en: en, vld: sq_vld[i]};
		scp_sqrt_cell #(
			.W  (W),
			.PW (PW1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (sq_ctl[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.rad_in   (sq_rad[i]),
			.pay_in   (sq_pay[i]),
			.vld_out  (sq_vld[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.rad_out  (sq_rad[i+1]),
			.pay_out  (sq_pay[i+1])
		);
	end

	assign {r_neg, r_head, r_ta, r_tb, r_shift, r_ma, r_mb} = sq_pay[W];
	assign norm = sq_root[W];

	always_comb begin
		hdiff  = {r_head[W-1], r_head} - {r_shift[W-1], r_shift};
		cm     = hdiff[W] ? (~hdiff) + (W+1)'(1) : hdiff;
		c_neg  = (hdiff[W] ? !r_neg : r_neg) && (cm != '0);
		n_le   = ({1'b0, norm} <= cm);
		tsum   = c_neg ? ({2'b00, norm} - {1'b0, cm}) : ({2'b00, norm} + {1'b0, cm});
		t_val  = tsum[W:1];
		sh_sum = r_neg ? ({{2{r_shift[W-1]}}, r_shift} - {2'b00, t_val})
		               : ({{2{r_shift[W-1]}}, r_shift} + {2'b00, t_val});
		if ((sh_sum[W+1] == sh_sum[W]) && (sh_sum[W] == sh_sum[W-1])) begin
			rh_sat = sh_sum[W-1:0];
		end else if (sh_sum[W+1]) begin
			rh_sat = SAT_MIN;
		end else begin
			rh_sat = SAT_MAX;
		end
		if (!n_le) begin
			kase = CASE_SURFACE;
		end else if (c_neg) begin
			kase = CASE_APEX;
		end else begin
			kase = CASE_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kase_s4  <= kase;
			rh_s4    <= rh_sat;
			head_s4  <= r_head;
			ta_s4    <= r_ta;
			tb_s4    <= r_tb;
			shift_s4 <= r_shift;
			ma_s4    <= r_ma;
			mb_s4    <= r_mb;
			t_s4     <= t_val;
			norm_s4  <= norm;

			pa_s5   <= ma_s4 * t_s4;
			pb_s5   <= mb_s4 * t_s4;
			norm_s5 <= norm_s4;
			pay_s5  <= {kase_s4, head_s4, ta_s4, tb_s4, shift_s4, rh_s4};
		end
	end

	assign dv_vld[0]   = vld_s5;
	assign dv_rem_a[0] = pa_s5[2*W-1:W];
	assign dv_low_a[0] = pa_s5[W-1:0];
	assign dv_rem_b[0] = pb_s5[2*W-1:W];
	assign dv_low_b[0] = pb_s5[W-1:0];
	assign dv_den[0]   = norm_s5;
	assign dv_pay[0]   = pay_s5;

	for (genvar i = 0; i < W; i++) begin : g_div
		assign dv_ctl[i] = '{en: en, vld: dv_vld[i]};
		scp_div_cell #(
			.W  (W),
			.PW (PW2)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (dv_ctl[i]),
			.rem_a_in  (dv_rem_a[i]),
			.low_a_in  (dv_low_a[i]),
			.rem_b_in  (dv_rem_b[i]),
			.low_b_in  (dv_low_b[i]),
			.den_in    (dv_den[i]),
			.pay_in    (dv_pay[i]),
			.vld_out   (dv_vld[i+1]),
			.rem_a_out (dv_rem_a[i+1]),
			.low_a_out (dv_low_a[i+1]),
			.rem_b_out (dv_rem_b[i+1]),
			.low_b_out (dv_low_b[i+1]),
			.den_out   (dv_den[i+1]),
			.pay_out   (dv_pay[i+1])
		);
	end

	assign {f_kase, f_head, f_ta, f_tb, f_shift, f_rh} = dv_pay[W];
	assign f_ra = f_ta[W-1] ? (~dv_low_a[W]) + W'(1) : dv_low_a[W];
	assign f_rb = f_tb[W-1] ? (~dv_low_b[W]) + W'(1) : dv_low_b[W];

	always_comb begin
		case (f_kase)
			CASE_INSIDE:  f_data = {f_tb, f_ta, f_head};
			CASE_APEX:    f_data = {{(2*W){1'b0}}, f_shift};
			CASE_SURFACE: f_data = {f_rb, f_ra, f_rh};
			default:      f_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_vld_q && !m_tready) begin
				skid_vld_q <= dv_vld[W];
			end else begin
				out_vld_q <= dv_vld[W];
			end
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_vld_q && !m_tready) begin
				skid_data_q <= f_data;
				skid_kase_q <= f_kase;
			end else begin
				out_data_q <= f_data;
				out_kase_q <= f_kase;
			end
		end else if (m_tready) begin
			out_data_q <= skid_data_q;
			out_kase_q <= skid_kase_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TW'(out_data_q);
	assign m_tuser  = out_kase_q;

endmodule

// ===== rtl/core/scp_checker.sv =====
// ----------------------------------------------------------------------------
// Shifted cone projection checker
// Port-level properties of the cone projection block, bound to its top level.
// ----------------------------------------------------------------------------
`include "shifted_cone_projection_3d_defines.svh"

module scp_checker #(
	parameter int DATA_WIDTH = scp_pkg::DATA_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	input logic [1:0]                        m_tuser
);
	import scp_pkg::*;

	localparam int W = DATA_WIDTH;

	`SCP_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid, "output transaction dropped while stalled")
	`SCP_ASSERT_SAME(a_case_code, m_tvalid, m_tuser != 2'd3, "undefined case code on output")
	`SCP_ASSERT_SAME(a_apex_tail, m_tvalid && (m_tuser == CASE_APEX), m_tdata[3*W-1:W] == '0, "apex result with nonzero tail")
	`SCP_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid, "input stalled with no output pending")

endmodule

bind shifted_cone_projection_3d scp_checker #(.DATA_WIDTH(DATA_WIDTH)) u_scp_checker (.*);
